>>> hw/rtl/pwo_pkg.sv
// Shared definitions for the mobility-model squared-error block.
// Holds sizes, item and fault codes, the sequencer state type and divider
// handshake structs. No dependencies.
package pwo_pkg;

  localparam int MAX_LOC = 64;
  localparam int IDX_W   = $clog2(MAX_LOC);
  localparam int CELL_W  = 2 * IDX_W;
  localparam int CELLS   = MAX_LOC * MAX_LOC;
  localparam int CNT_W   = 7;

  localparam int VAL_W   = 32;
  localparam int POP_W   = 24;
  localparam int OPP_W   = 30;
  localparam int OUT_W   = 38;
  localparam int RECIP_W = 47;
  localparam int TERM_W  = 47;
  localparam int DEN_W   = 52;
  localparam int SHARE_W = 31;
  localparam int ACC_W   = 64;
  localparam int MUL_W   = 32;
  localparam int STEP_W  = 6;

  localparam int LONG_Q  = 46;
  localparam int SHORT_Q = 30;

  localparam logic [RECIP_W-1:0] ONE_LONG  = RECIP_W'(1) << LONG_Q;
  localparam logic [RECIP_W-1:0] ONE_SHORT = RECIP_W'(1) << SHORT_Q;

  localparam logic [1:0] FUNC_DIST    = 2'd0;
  localparam logic [1:0] FUNC_FLOW    = 2'd1;
  localparam logic [1:0] FUNC_POP     = 2'd2;
  localparam logic [1:0] FUNC_COMPUTE = 2'd3;

  localparam logic [1:0] FAULT_OK      = 2'd0;
  localparam logic [1:0] FAULT_OUTFLOW = 2'd1;
  localparam logic [1:0] FAULT_OPP     = 2'd2;
  localparam logic [1:0] FAULT_DENOM   = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE, S_A_RUN, S_A_END,
    S_B_PAIR, S_B_LAT, S_B_RUN, S_B_END, S_B_STEP,
    S_M_RUN, S_M_DST, S_M_DW,
    S_C_ROW, S_C_DPAIR, S_C_DLAT, S_C_DDIV, S_C_DMH, S_C_DML, S_C_DTERM,
    S_C_DACC, S_C_DSTEP, S_C_DCHK, S_C_OLAT,
    S_C_RPAIR, S_C_RLAT, S_C_RDA, S_C_RSB, S_C_RDB, S_C_RSQ, S_C_RACC,
    S_C_RSTEP, S_C_NROW, S_DONE
  } state_t;

  typedef struct packed {
    logic             start;
    logic             long_q;
    logic [DEN_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> hw/rtl/pwo_model_squared_error.sv
// Top level of the mobility-model squared-error evaluator.
// Depends on pwo_pkg, pwo_ram, pwo_div and pwo_mul.
//
// Usage:
//   Input channel (in_valid/in_ready) carries func, row, col, value.
//   Load items (distance, flow, population) are written to on-chip memories
//   in the cycle they are accepted and produce no result item. A compute item
//   scores the prediction over the first n locations and produces one result
//   item (error_sum, fault) on the out_valid/out_ready channel.
//   cfg_we/cfg_wdata set location_count (n); values below 2 act as 2, above
//   64 as 64. Write it only while the block is idle.
// Timing:
//   in_ready is high whenever the block is idle. A compute item first sums
//   outflows, then opportunity sums (one distance read per cycle), and per
//   ordered pair the reciprocal and weighting and the two shares; each
//   division runs on the shared divider, producing one quotient bit per
//   cycle. A fault ends the compute early. in_ready stays low meanwhile.
// Reset:
//   rst clears the sequencer, output valid and sets n to 64. Memory contents
//   are not cleared; every entry must be loaded before a compute uses it.
// Stall:
//   The result sits in an output register; load items are still accepted
//   while it waits. A following compute finishes its work and then holds
//   until the previous result has been taken.
module pwo_model_squared_error (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pwo_pkg::CNT_W-1:0]       cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      func,
  input  logic [pwo_pkg::IDX_W-1:0]       row,
  input  logic [pwo_pkg::IDX_W-1:0]       col,
  input  logic [pwo_pkg::VAL_W-1:0]       value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pwo_pkg::ACC_W-1:0]       error_sum,
  output logic [1:0]                      fault
);

  pwo_pkg::state_t state, state_next;

  logic [pwo_pkg::CNT_W-1:0]   location_count;
  logic [pwo_pkg::CNT_W-1:0]   n_clamp;
  logic [pwo_pkg::IDX_W-1:0]   n_last;
  logic [pwo_pkg::IDX_W-1:0]   cnt_i, cnt_j, cnt_k, pipe_k;
  logic                        issued_all, pipe_v, pipe_last, issue, run_state;
  logic                        i_last, j_last, k_last;
  logic                        in_acc;

  logic [1:0]                  fault_code;
  logic [pwo_pkg::OUT_W-1:0]   sum_o, o_reg;
  logic [pwo_pkg::OPP_W-1:0]   sum_s, total_m;
  logic [pwo_pkg::VAL_W-1:0]   dij;
  logic [pwo_pkg::RECIP_W-1:0] recip_m, exc, quot;
  logic [pwo_pkg::POP_W-1:0]   p_reg;
  logic [47:0]                 mq, term_low;
  logic [pwo_pkg::TERM_W-1:0]  term_reg, tj;
  logic [pwo_pkg::DEN_W-1:0]   denom;
  logic [pwo_pkg::SHARE_W-1:0] a_reg, rabs, r_abs;
  logic [pwo_pkg::SHARE_W:0]   r_diff;
  logic [pwo_pkg::ACC_W-1:0]   acc;
  logic [pwo_pkg::ACC_W:0]     acc_sum;

  // memory ports
  logic                        dist_we, flow_we, pop_we, opp_we, out_we, term_we;
  logic [pwo_pkg::CELL_W-1:0]  dist_raddr, flow_raddr;
  logic [pwo_pkg::VAL_W-1:0]   dist_rdata, flow_rdata;
  logic [pwo_pkg::POP_W-1:0]   pop_rdata;
  logic [pwo_pkg::OPP_W-1:0]   opp_rdata;
  logic [pwo_pkg::OUT_W-1:0]   out_rdata;
  logic [pwo_pkg::TERM_W-1:0]  term_rdata;

  pwo_pkg::div_req_t           div_req;
  pwo_pkg::div_stat_t          div_stat;
  logic [pwo_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic [2*pwo_pkg::MUL_W-1:0] mul_p;

  assign in_ready = (state == pwo_pkg::S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // clamp n into the supported range
  always_comb begin
    if (location_count < pwo_pkg::CNT_W'(2)) begin
      n_clamp = pwo_pkg::CNT_W'(2);
    end else if (location_count > pwo_pkg::CNT_W'(pwo_pkg::MAX_LOC)) begin
      n_clamp = pwo_pkg::CNT_W'(pwo_pkg::MAX_LOC);
    end else begin
      n_clamp = location_count;
    end
  end

  assign i_last = (cnt_i == n_last);
  assign j_last = (cnt_j == n_last);
  assign k_last = (cnt_k == n_last);

  // streaming loops issue one read a cycle; the pipe flags follow the data
  assign run_state = (state == pwo_pkg::S_A_RUN) || (state == pwo_pkg::S_B_RUN) ||
                     (state == pwo_pkg::S_M_RUN);
  assign issue     = run_state && !issued_all;

  // weighting: floor(p * e / 2^24) from the high and low partial products
  assign term_low = {24'd0, mq[0], 23'd0} + mul_p[47:0];

  assign r_diff  = {1'b0, a_reg} - {1'b0, quot[pwo_pkg::SHARE_W-1:0]};
  assign r_abs   = r_diff[pwo_pkg::SHARE_W] ? pwo_pkg::SHARE_W'(-r_diff)
                                            : r_diff[pwo_pkg::SHARE_W-1:0];
  assign acc_sum = {1'b0, acc} + (pwo_pkg::ACC_W + 1)'(mul_p[63:12]);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pwo_pkg::S_IDLE:
        if (in_acc && func == pwo_pkg::FUNC_COMPUTE) state_next = pwo_pkg::S_A_RUN;
      pwo_pkg::S_A_RUN:
        if (pipe_v && pipe_last) state_next = pwo_pkg::S_A_END;
      pwo_pkg::S_A_END: begin
        if (!i_last) begin
          state_next = pwo_pkg::S_A_RUN;
        end else if (fault_code != pwo_pkg::FAULT_OK || sum_o == '0) begin
          state_next = pwo_pkg::S_DONE;
        end else begin
          state_next = pwo_pkg::S_B_PAIR;
        end
      end
      pwo_pkg::S_B_PAIR:
        state_next = (cnt_j == cnt_i) ? pwo_pkg::S_B_STEP : pwo_pkg::S_B_LAT;
      pwo_pkg::S_B_LAT:  state_next = pwo_pkg::S_B_RUN;
      pwo_pkg::S_B_RUN:
        if (pipe_v && pipe_last) state_next = pwo_pkg::S_B_END;
      pwo_pkg::S_B_END:  state_next = pwo_pkg::S_B_STEP;
      pwo_pkg::S_B_STEP: begin
        if (j_last && i_last) begin
          state_next = (fault_code != pwo_pkg::FAULT_OK) ? pwo_pkg::S_DONE
                                                         : pwo_pkg::S_M_RUN;
        end else begin
          state_next = pwo_pkg::S_B_PAIR;
        end
      end
      pwo_pkg::S_M_RUN:
        if (pipe_v && pipe_last) state_next = pwo_pkg::S_M_DST;
      pwo_pkg::S_M_DST:  state_next = pwo_pkg::S_M_DW;
      pwo_pkg::S_M_DW:
        if (div_stat.done) state_next = pwo_pkg::S_C_ROW;
      pwo_pkg::S_C_ROW:  state_next = pwo_pkg::S_C_DPAIR;
      pwo_pkg::S_C_DPAIR:
        state_next = (cnt_k == cnt_i) ? pwo_pkg::S_C_DSTEP : pwo_pkg::S_C_DLAT;
      pwo_pkg::S_C_DLAT: state_next = pwo_pkg::S_C_DDIV;
      pwo_pkg::S_C_DDIV:
        if (div_stat.done) state_next = pwo_pkg::S_C_DMH;
      pwo_pkg::S_C_DMH:   state_next = pwo_pkg::S_C_DML;
      pwo_pkg::S_C_DML:   state_next = pwo_pkg::S_C_DTERM;
      pwo_pkg::S_C_DTERM: state_next = pwo_pkg::S_C_DACC;
      pwo_pkg::S_C_DACC:  state_next = pwo_pkg::S_C_DSTEP;
      pwo_pkg::S_C_DSTEP:
        state_next = k_last ? pwo_pkg::S_C_DCHK : pwo_pkg::S_C_DPAIR;
      pwo_pkg::S_C_DCHK:
        state_next = (denom == '0) ? pwo_pkg::S_DONE : pwo_pkg::S_C_OLAT;
      pwo_pkg::S_C_OLAT:  state_next = pwo_pkg::S_C_RPAIR;
      pwo_pkg::S_C_RPAIR:
        state_next = (cnt_j == cnt_i) ? pwo_pkg::S_C_RSTEP : pwo_pkg::S_C_RLAT;
      pwo_pkg::S_C_RLAT:  state_next = pwo_pkg::S_C_RDA;
      pwo_pkg::S_C_RDA:
        if (div_stat.done) state_next = pwo_pkg::S_C_RSB;
      pwo_pkg::S_C_RSB:   state_next = pwo_pkg::S_C_RDB;
      pwo_pkg::S_C_RDB:
        if (div_stat.done) state_next = pwo_pkg::S_C_RSQ;
      pwo_pkg::S_C_RSQ:   state_next = pwo_pkg::S_C_RACC;
      pwo_pkg::S_C_RACC:  state_next = pwo_pkg::S_C_RSTEP;
      pwo_pkg::S_C_RSTEP:
        state_next = j_last ? pwo_pkg::S_C_NROW : pwo_pkg::S_C_RPAIR;
      pwo_pkg::S_C_NROW:
        state_next = i_last ? pwo_pkg::S_DONE : pwo_pkg::S_C_ROW;
      pwo_pkg::S_DONE:
        if (!out_valid || out_ready) state_next = pwo_pkg::S_IDLE;
      default: state_next = pwo_pkg::S_IDLE;
    endcase
  end

  // memory, divider and multiplier controls
  always_comb begin
    dist_we    = in_acc && (func == pwo_pkg::FUNC_DIST);
    flow_we    = in_acc && (func == pwo_pkg::FUNC_FLOW);
    pop_we     = in_acc && (func == pwo_pkg::FUNC_POP);
    opp_we     = (state == pwo_pkg::S_B_END);
    out_we     = (state == pwo_pkg::S_A_END);
    term_we    = (state == pwo_pkg::S_C_DACC);
    dist_raddr = (state == pwo_pkg::S_B_RUN) ? {cnt_k, cnt_i} : {cnt_i, cnt_j};
    flow_raddr = (state == pwo_pkg::S_A_RUN) ? {cnt_i, cnt_k} : {cnt_i, cnt_j};

    div_req = '0;
    case (state)
      pwo_pkg::S_M_DST: begin
        div_req.start  = 1'b1;
        div_req.long_q = 1'b1;
        div_req.num    = pwo_pkg::DEN_W'(1);
        div_req.den    = pwo_pkg::DEN_W'(total_m);
      end
      pwo_pkg::S_C_DLAT: begin
        div_req.start  = 1'b1;
        div_req.long_q = 1'b1;
        div_req.num    = pwo_pkg::DEN_W'(1);
        div_req.den    = pwo_pkg::DEN_W'(opp_rdata);
      end
      pwo_pkg::S_C_RLAT: begin
        div_req.start  = 1'b1;
        div_req.num    = pwo_pkg::DEN_W'(flow_rdata);
        div_req.den    = pwo_pkg::DEN_W'(o_reg);
      end
      pwo_pkg::S_C_RSB: begin
        div_req.start  = 1'b1;
        div_req.num    = pwo_pkg::DEN_W'(tj);
        div_req.den    = denom;
      end
      default: div_req = '0;
    endcase

    case (state)
      pwo_pkg::S_C_DMH: begin
        mul_a = pwo_pkg::MUL_W'(p_reg);
        mul_b = pwo_pkg::MUL_W'(exc[46:23]);
      end
      pwo_pkg::S_C_DML: begin
        mul_a = pwo_pkg::MUL_W'(p_reg);
        mul_b = pwo_pkg::MUL_W'(exc[22:0]);
      end
      pwo_pkg::S_C_RSQ: begin
        mul_a = pwo_pkg::MUL_W'(rabs);
        mul_b = pwo_pkg::MUL_W'(rabs);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= pwo_pkg::S_IDLE;
      location_count <= pwo_pkg::CNT_W'(pwo_pkg::MAX_LOC);
      out_valid      <= 1'b0;
      pipe_v         <= 1'b0;
      pipe_last      <= 1'b0;
      issued_all     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) location_count <= cfg_wdata;
      // load a finished result, or drop the one just taken
      if (state == pwo_pkg::S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      pipe_v    <= issue;
      pipe_last <= issue && k_last;
      pipe_k    <= cnt_k;
      if (issue) begin
        cnt_k <= cnt_k + 1'b1;
        if (k_last) issued_all <= 1'b1;
      end

      case (state)
        pwo_pkg::S_IDLE:
          if (in_acc && func == pwo_pkg::FUNC_COMPUTE) begin
            n_last     <= pwo_pkg::IDX_W'(n_clamp - 1'b1);
            cnt_i      <= '0;
            cnt_k      <= '0;
            issued_all <= 1'b0;
            sum_o      <= '0;
            fault_code <= pwo_pkg::FAULT_OK;
            acc        <= '0;
          end
        pwo_pkg::S_A_RUN:
          if (pipe_v && pipe_k != cnt_i) sum_o <= sum_o + pwo_pkg::OUT_W'(flow_rdata);
        pwo_pkg::S_A_END: begin
          if (sum_o == '0) fault_code <= pwo_pkg::FAULT_OUTFLOW;
          if (!i_last) begin
            cnt_i      <= cnt_i + 1'b1;
            cnt_k      <= '0;
            issued_all <= 1'b0;
            sum_o      <= '0;
          end else begin
            cnt_i <= '0;
            cnt_j <= '0;
          end
        end
        pwo_pkg::S_B_LAT: begin
          dij        <= dist_rdata;
          cnt_k      <= '0;
          issued_all <= 1'b0;
          sum_s      <= '0;
        end
        pwo_pkg::S_B_RUN:
          if (pipe_v && pipe_k != cnt_j && dij >= dist_rdata) begin
            sum_s <= sum_s + pwo_pkg::OPP_W'(pop_rdata);
          end
        pwo_pkg::S_B_END:
          if (sum_s == '0 && fault_code == pwo_pkg::FAULT_OK) fault_code <= pwo_pkg::FAULT_OPP;
        pwo_pkg::S_B_STEP: begin
          if (j_last) begin
            cnt_j <= '0;
            if (!i_last) begin
              cnt_i <= cnt_i + 1'b1;
            end else begin
              cnt_k      <= '0;
              issued_all <= 1'b0;
              total_m    <= '0;
            end
          end else begin
            cnt_j <= cnt_j + 1'b1;
          end
        end
        pwo_pkg::S_M_RUN:
          if (pipe_v) total_m <= total_m + pwo_pkg::OPP_W'(pop_rdata);
        pwo_pkg::S_M_DW:
          if (div_stat.done) begin
            recip_m <= quot;
            cnt_i   <= '0;
          end
        pwo_pkg::S_C_ROW: begin
          denom <= '0;
          cnt_k <= '0;
        end
        pwo_pkg::S_C_DLAT: p_reg <= pop_rdata;
        pwo_pkg::S_C_DDIV:
          // 1/S - 1/M, floored at zero
          if (div_stat.done) exc <= (quot > recip_m) ? quot - recip_m : '0;
        pwo_pkg::S_C_DML:   mq <= mul_p[47:0];
        pwo_pkg::S_C_DTERM:
          term_reg <= pwo_pkg::TERM_W'(mq >> 1) + pwo_pkg::TERM_W'(term_low >> 24);
        pwo_pkg::S_C_DACC:  denom <= denom + pwo_pkg::DEN_W'(term_reg);
        pwo_pkg::S_C_DSTEP:
          if (!k_last) begin
            cnt_k <= cnt_k + 1'b1;
          end else begin
            cnt_j <= '0;
          end
        pwo_pkg::S_C_DCHK:
          if (denom == '0) fault_code <= pwo_pkg::FAULT_DENOM;
        pwo_pkg::S_C_OLAT:  o_reg <= out_rdata;
        pwo_pkg::S_C_RLAT:  tj <= term_rdata;
        pwo_pkg::S_C_RDA:
          if (div_stat.done) a_reg <= quot[pwo_pkg::SHARE_W-1:0];
        pwo_pkg::S_C_RDB:
          if (div_stat.done) rabs <= r_abs;
        pwo_pkg::S_C_RACC:
          // saturate at all ones
          acc <= acc_sum[pwo_pkg::ACC_W] ? {pwo_pkg::ACC_W{1'b1}} : acc_sum[pwo_pkg::ACC_W-1:0];
        pwo_pkg::S_C_RSTEP:
          if (!j_last) cnt_j <= cnt_j + 1'b1;
        pwo_pkg::S_C_NROW:
          if (!i_last) cnt_i <= cnt_i + 1'b1;
        pwo_pkg::S_DONE:
          if (!out_valid || out_ready) begin
            error_sum <= (fault_code == pwo_pkg::FAULT_OK) ? acc : '0;
            fault     <= fault_code;
          end
        default: ;
      endcase
    end
  end

  pwo_ram #(.WIDTH(pwo_pkg::VAL_W), .DEPTH(pwo_pkg::CELLS)) u_dist_ram (
    .clk(clk), .we(dist_we), .waddr({row, col}), .wdata(value),
    .raddr(dist_raddr), .rdata(dist_rdata)
  );

  pwo_ram #(.WIDTH(pwo_pkg::VAL_W), .DEPTH(pwo_pkg::CELLS)) u_flow_ram (
    .clk(clk), .we(flow_we), .waddr({row, col}), .wdata(value),
    .raddr(flow_raddr), .rdata(flow_rdata)
  );

  pwo_ram #(.WIDTH(pwo_pkg::POP_W), .DEPTH(pwo_pkg::MAX_LOC)) u_pop_ram (
    .clk(clk), .we(pop_we), .waddr(row), .wdata(value[pwo_pkg::POP_W-1:0]),
    .raddr(cnt_k), .rdata(pop_rdata)
  );

  pwo_ram #(.WIDTH(pwo_pkg::OPP_W), .DEPTH(pwo_pkg::CELLS)) u_opp_ram (
    .clk(clk), .we(opp_we), .waddr({cnt_i, cnt_j}), .wdata(sum_s),
    .raddr({cnt_i, cnt_k}), .rdata(opp_rdata)
  );

  pwo_ram #(.WIDTH(pwo_pkg::OUT_W), .DEPTH(pwo_pkg::MAX_LOC)) u_out_ram (
    .clk(clk), .we(out_we), .waddr(cnt_i), .wdata(sum_o),
    .raddr(cnt_i), .rdata(out_rdata)
  );

  pwo_ram #(.WIDTH(pwo_pkg::TERM_W), .DEPTH(pwo_pkg::MAX_LOC)) u_term_ram (
    .clk(clk), .we(term_we), .waddr(cnt_k), .wdata(term_reg),
    .raddr(cnt_j), .rdata(term_rdata)
  );

  pwo_div u_div (
    .clk(clk), .rst(rst), .req(div_req), .stat(div_stat), .quot(quot)
  );

  pwo_mul u_mul (
    .clk(clk), .a(mul_a), .b(mul_b), .p(mul_p)
  );

  // a faulted result always reports zero error
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && fault != pwo_pkg::FAULT_OK) |-> (error_sum == '0))
    else $error("faulted result carries nonzero error_sum");

  // streamed read data only arrives inside a streaming loop
  a_pipe_scope: assert property (@(posedge clk) disable iff (rst)
    pipe_v |-> (state == pwo_pkg::S_A_RUN || state == pwo_pkg::S_B_RUN ||
                state == pwo_pkg::S_M_RUN))
    else $error("read pipeline valid outside a streaming loop");

  // never restart the divider mid-operation
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_stat.busy)
    else $error("divider started while busy");

  // hold the finished compute while the previous result is still pending
  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (state == pwo_pkg::S_DONE && out_valid && !out_ready) |=> (state == pwo_pkg::S_DONE))
    else $error("result overwritten while stalled");

endmodule

>>> hw/rtl/pwo_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pwo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/pwo_div.sv
// Shared restoring divider: floor(num * 2^q / den), one quotient bit a cycle.
// Depends on pwo_pkg.
module pwo_div (
  input  logic                           clk,
  input  logic                           rst,
  input  pwo_pkg::div_req_t              req,
  output pwo_pkg::div_stat_t             stat,
  output logic [pwo_pkg::RECIP_W-1:0]    quot
);

  logic [pwo_pkg::DEN_W-1:0]  rem;
  logic [pwo_pkg::DEN_W-1:0]  den;
  logic [pwo_pkg::DEN_W:0]    rem2;
  logic [pwo_pkg::DEN_W:0]    diff;
  logic [pwo_pkg::STEP_W-1:0] steps;
  logic                       take;
  logic                       busy;
  logic                       done;

  assign rem2 = {rem, 1'b0};
  assign diff = rem2 - {1'b0, den};
  assign take = !diff[pwo_pkg::DEN_W];

  assign stat.busy = busy;
  assign stat.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        if (req.den == '0) begin
          quot <= '0;
          done <= 1'b1;
        end else if (req.num >= req.den) begin
          // quotient saturates at one
          quot <= req.long_q ? pwo_pkg::ONE_LONG : pwo_pkg::ONE_SHORT;
          done <= 1'b1;
        end else begin
          rem   <= req.num;
          den   <= req.den;
          quot  <= '0;
          steps <= req.long_q ? pwo_pkg::STEP_W'(pwo_pkg::LONG_Q)
                              : pwo_pkg::STEP_W'(pwo_pkg::SHORT_Q);
          busy  <= 1'b1;
        end
      end else if (busy) begin
        rem   <= take ? diff[pwo_pkg::DEN_W-1:0] : rem2[pwo_pkg::DEN_W-1:0];
        quot  <= {quot[pwo_pkg::RECIP_W-2:0], take};
        steps <= steps - 1'b1;
        if (steps == pwo_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hw/rtl/pwo_mul.sv
// Shared 32x32 multiplier with registered product.
// Depends on pwo_pkg.
module pwo_mul (
  input  logic                          clk,
  input  logic [pwo_pkg::MUL_W-1:0]     a,
  input  logic [pwo_pkg::MUL_W-1:0]     b,
  output logic [2*pwo_pkg::MUL_W-1:0]   p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
